// File: rtl/stick_vector_to_heading_defines.svh
// Assertion macros for the stick vector to heading block.
// Used by the checker module; depends on nothing else.
`ifndef STICK_VECTOR_TO_HEADING_DEFINES_SVH
`define STICK_VECTOR_TO_HEADING_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define STVH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("stvh assertion failed");

// Next-cycle implication, held off during reset.
`define STVH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("stvh assertion failed");

`endif

// File: rtl/stvh_pkg.sv
// Shared types, constants and the arctangent step table for the heading block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stvh_pkg;

	localparam int STEPS     = 20;   // CORDIC iterations
	localparam int VEC_SHIFT = 24;   // vector scaling
	localparam int VEC_W     = 36;   // vector register width
	localparam int Z_W       = 25;   // angle accumulator, 2^-16 degree units
	localparam int ANG_FRAC  = 16;
	localparam int ANG_W     = 23;   // clamped angle, 0..90 degrees
	localparam int PROD_W    = 30;
	localparam int T_W       = 14;   // centidegrees inside one quadrant
	localparam int MAG_W     = 8;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic signed [Z_W-1:0] Z_MAX     = Z_W'(90 * 65536);
	localparam logic [PROD_W-1:0]     CENTI     = PROD_W'(100);
	localparam logic [PROD_W-1:0]     ROUND_ADD = PROD_W'(32768);

	localparam logic [15:0] HEADING_NORTH = 16'd0;
	localparam logic [15:0] HEADING_EAST  = 16'd9000;
	localparam logic [15:0] HEADING_SOUTH = 16'd18000;
	localparam logic [15:0] HEADING_WEST  = 16'd27000;
	localparam logic [15:0] HEADING_FULL  = 16'd36000;

	// Where the stick points; QD_W also covers the origin.
	typedef enum logic [2:0] {
		QD_NE, QD_SE, QD_SW, QD_NW, QD_N, QD_S, QD_E, QD_W
	} stvh_quad_t;

	// One classified word between front and back.
	typedef struct packed {
		stvh_quad_t       quad;
		logic [MAG_W-1:0] opp;
		logic [MAG_W-1:0] adj;
		logic [7:0]       force_val;
	} stvh_item_t;

	// atan(2^-i) in degrees, scaled by 65536 and rounded.
	function automatic logic signed [Z_W-1:0] atan_step(input int i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			0:  r = Z_W'(2949120);
			1:  r = Z_W'(1740967);
			2:  r = Z_W'(919879);
			3:  r = Z_W'(466945);
			4:  r = Z_W'(234379);
			5:  r = Z_W'(117304);
			6:  r = Z_W'(58666);
			7:  r = Z_W'(29335);
			8:  r = Z_W'(14668);
			9:  r = Z_W'(7334);
			10: r = Z_W'(3667);
			11: r = Z_W'(1833);
			12: r = Z_W'(917);
			13: r = Z_W'(458);
			14: r = Z_W'(229);
			15: r = Z_W'(115);
			16: r = Z_W'(57);
			17: r = Z_W'(29);
			18: r = Z_W'(14);
			19: r = Z_W'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/stvh_front.sv
// Front end: takes stick samples, classifies the direction, picks the CORDIC operands.
// Depends on stvh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stvh_front (
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [7:0] x_position,
	input  wire logic signed [7:0] y_position,
	input  wire logic              q_full,
	output logic                   push,
	output stvh_pkg::stvh_item_t   item
);
	import stvh_pkg::*;

	logic             xp, xn, yp, yn;
	logic [MAG_W-1:0] ax, ay;
	logic [8:0]       fsum;
	stvh_quad_t       quad;

	// a word enters whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// magnitudes; -128 gives 128 unsigned
	assign ax = x_position[7] ? MAG_W'(-x_position) : MAG_W'(x_position);
	assign ay = y_position[7] ? MAG_W'(-y_position) : MAG_W'(y_position);

	assign xn = x_position[7];
	assign yn = y_position[7];
	assign xp = !xn && (x_position != '0);
	assign yp = !yn && (y_position != '0);

	// direction class, diagonals first, then axes
	always_comb begin
		priority if (xp && yp) begin
			quad = QD_NE;
		end else if (xp && yn) begin
			quad = QD_SE;
		end else if (xn && yn) begin
			quad = QD_SW;
		end else if (xn && yp) begin
			quad = QD_NW;
		end else if (yp) begin
			quad = QD_N;
		end else if (yn) begin
			quad = QD_S;
		end else if (xp) begin
			quad = QD_E;
		end else begin
			quad = QD_W;
		end
	end

	// force with saturation, operands by half plane
	always_comb begin
		fsum           = {1'b0, ax} + {1'b0, ay};
		item.quad      = quad;
		item.force_val = fsum[8] ? 8'hFF : fsum[7:0];
		if (xn) begin
			item.opp = ax;
			item.adj = ay;
		end else begin
			item.opp = ay;
			item.adj = ax;
		end
	end

endmodule

`default_nettype wire

// File: rtl/stvh_queue.sv
// Short queue of classified words between front and back.
// Depends on stvh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stvh_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stvh_pkg::stvh_item_t wr_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  rd_valid,
	output stvh_pkg::stvh_item_t  rd_item
);
	import stvh_pkg::*;

	stvh_item_t          ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/stvh_back.sv
// Back end: pipelined CORDIC arctangent, rounding, heading assembly, output register.
// Depends on stvh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stvh_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire stvh_pkg::stvh_item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [15:0]           heading_centideg,
	output logic [7:0]            force_halves
);
	import stvh_pkg::*;

	logic                     adv;
	logic [STEPS:0]           vld_s;
	logic signed [VEC_W-1:0]  vx_s [STEPS+1];
	logic signed [VEC_W-1:0]  vy_s [STEPS+1];
	logic signed [Z_W-1:0]    vz_s [STEPS+1];
	stvh_quad_t               quad_s [STEPS+1];
	logic [7:0]               frc_s [STEPS+1];

	logic signed [VEC_W-1:0]  nx [STEPS];
	logic signed [VEC_W-1:0]  ny [STEPS];
	logic signed [Z_W-1:0]    nz [STEPS];

	logic [ANG_W-1:0]         zc;
	logic [PROD_W-1:0]        prod;
	logic                     vld_s21;
	logic [T_W-1:0]           ang_s21;
	stvh_quad_t               quad_s21;
	logic [7:0]               frc_s21;
	logic [15:0]              hd_raw, hd;
	logic                     out_vld_q;
	logic [15:0]              heading_q;
	logic [7:0]               force_q;

	// whole pipeline moves unless a finished word is held at the output
	assign adv   = !(out_vld_q && out_stall);
	assign q_pop = adv && q_valid;

	// one rotation per stage, each stage on its own registers
	always_comb begin
		for (int i = 0; i < STEPS; i++) begin
			if (!vy_s[i][VEC_W-1] && (vy_s[i] != '0)) begin
				nx[i] = vx_s[i] + (vy_s[i] >>> i);
				ny[i] = vy_s[i] - (vx_s[i] >>> i);
				nz[i] = vz_s[i] + atan_step(i);
			end else begin
				nx[i] = vx_s[i] - (vy_s[i] >>> i);
				ny[i] = vy_s[i] + (vx_s[i] >>> i);
				nz[i] = vz_s[i] - atan_step(i);
			end
		end
	end

	// CORDIC stage registers
	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s[0]   <= {{(VEC_W-MAG_W-VEC_SHIFT){1'b0}}, q_item.adj, {VEC_SHIFT{1'b0}}};
			vy_s[0]   <= {{(VEC_W-MAG_W-VEC_SHIFT){1'b0}}, q_item.opp, {VEC_SHIFT{1'b0}}};
			vz_s[0]   <= '0;
			quad_s[0] <= q_item.quad;
			frc_s[0]  <= q_item.force_val;
			for (int i = 0; i < STEPS; i++) begin
				vx_s[i+1]   <= nx[i];
				vy_s[i+1]   <= ny[i];
				vz_s[i+1]   <= nz[i];
				quad_s[i+1] <= quad_s[i];
				frc_s[i+1]  <= frc_s[i];
			end
		end
	end

	// clamp to 0..90 degrees and round to centidegrees
	always_comb begin
		if (vz_s[STEPS][Z_W-1]) begin
			zc = '0;
		end else if (vz_s[STEPS] > Z_MAX) begin
			zc = ANG_W'(Z_MAX);
		end else begin
			zc = ANG_W'(vz_s[STEPS]);
		end
		prod = PROD_W'(zc) * CENTI + ROUND_ADD;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s21  <= prod[ANG_FRAC +: T_W];
			quad_s21 <= quad_s[STEPS];
			frc_s21  <= frc_s[STEPS];
		end
	end

	// heading by direction class
	always_comb begin
		unique case (quad_s21)
			QD_NE: hd_raw = HEADING_EAST - 16'(ang_s21);
			QD_SE: hd_raw = HEADING_EAST + 16'(ang_s21);
			QD_SW: hd_raw = HEADING_SOUTH + 16'(ang_s21);
			QD_NW: hd_raw = HEADING_FULL - 16'(ang_s21);
			QD_N:  hd_raw = HEADING_NORTH;
			QD_S:  hd_raw = HEADING_SOUTH;
			QD_E:  hd_raw = HEADING_EAST;
			QD_W:  hd_raw = HEADING_WEST;
		endcase
		hd = (hd_raw >= HEADING_FULL) ? hd_raw - HEADING_FULL : hd_raw;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			heading_q <= hd;
			force_q   <= frc_s21;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			vld_s21   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[STEPS-1:0], q_valid};
			vld_s21   <= vld_s[STEPS];
			out_vld_q <= vld_s21;
		end
	end

	assign out_valid        = out_vld_q;
	assign heading_centideg = heading_q;
	assign force_halves     = force_q;

endmodule

`default_nettype wire

// File: rtl/stick_vector_to_heading.sv
// Top level of the stick vector to heading block.
// Depends on stvh_pkg, stvh_front, stvh_queue and stvh_back.
//
// Usage:
//   Input channel: in_valid / in_stall with x_position and y_position, signed
//   stick deflection. A word is taken at a clock edge with in_valid high and
//   in_stall low.
//   Output channel: out_valid / out_stall with heading_centideg (clockwise from
//   forward, 0.01 degree) and force_halves (|x| + |y|, saturated at 255).
//   Throughput: one sample per cycle unless out_stall holds the output; every
//   stage of the 20-step CORDIC has its own adders, so samples overlap freely.
//   Path to out_valid: an accepted sample passes the queue, 21 CORDIC register
//   stages, the rounding stage and the output register.
//   Reset: arst_n low empties the four-word queue and clears all stage valid
//   bits; nothing is shown at the output until a new sample has passed.
//   Receiver stall: the CORDIC pipeline and output register hold; the front
//   keeps taking samples until the four-word queue fills, then raises in_stall.
`timescale 1ns / 1ps
`default_nettype none

module stick_vector_to_heading (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [7:0] x_position,
	input  wire logic signed [7:0] y_position,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [15:0]            heading_centideg,
	output logic [7:0]             force_halves
);
	import stvh_pkg::*;

	stvh_item_t f_item, q_item;
	logic       push, q_full, q_valid, q_pop;

	// classification
	stvh_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_position (x_position),
		.y_position (y_position),
		.q_full     (q_full),
		.push       (push),
		.item       (f_item)
	);

	// decoupling queue
	stvh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	// arctangent pipeline and output
	stvh_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.heading_centideg (heading_centideg),
		.force_halves     (force_halves)
	);

endmodule

`default_nettype wire

// File: rtl/stvh_checker.sv
// Port-level checks for the stick vector to heading block, bound to the top level.
// Depends on stvh_pkg and stick_vector_to_heading_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stick_vector_to_heading_defines.svh"

module stvh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] heading_centideg,
	input wire logic [7:0]  force_halves
);
	import stvh_pkg::*;

	// a held result stays offered and unchanged
	`STVH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`STVH_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(heading_centideg) && $stable(force_halves))

	// heading always wraps into one turn
	`STVH_ASSERT_NOW(a_heading_range, clk, arst_n, out_valid, heading_centideg < HEADING_FULL)

	// zero force means the origin, which points west
	`STVH_ASSERT_NOW(a_origin_west, clk, arst_n, out_valid && (force_halves == 8'd0), heading_centideg == HEADING_WEST)

endmodule

bind stick_vector_to_heading stvh_checker u_stvh_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.heading_centideg (heading_centideg),
	.force_halves     (force_halves)
);

`default_nettype wire
